[src/grouped_sorted_table_binary_search_defines.svh]
// assertion macros for the block's datapath module
`ifndef GROUPED_SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define GROUPED_SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GSTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define GSTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/gsts_pkg.sv]
// shared types, constants and key normalization for the sorted table search
package gsts_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned KeyBytesDefault   = 8;

  localparam int unsigned TEXT_W = 64;
  localparam int unsigned GS_W   = 5;
  localparam int unsigned POS_W  = 4;

  localparam logic [GS_W-1:0] GS_RESET = 5'd4;
  localparam logic [GS_W-1:0] GS_MIN   = 5'd1;
  localparam logic [GS_W-1:0] GS_MAX   = 5'd16;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE
  } state_t;

  typedef struct packed {
    logic load;
    logic set_label;
    logic start;
    logic advance;
    logic probe;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic pos_zero;
    logic count_zero;
    logic key_eq;
    logic range_done;
    logic out_free;
  } status_t;

  // clear every byte from the first zero byte down, keep the top kb bytes
  function automatic logic [TEXT_W-1:0] normalize(input logic [TEXT_W-1:0] t, input int kb);
    logic [TEXT_W-1:0] r;
    logic run;
    r   = '0;
    run = 1'b1;
    for (int b = 7; b >= 0; b--) begin
      if (t[8*b +: 8] == 8'h00) begin
        run = 1'b0;
      end
      if (run && (b >= 8 - kb)) begin
        r[8*b +: 8] = t[8*b +: 8];
      end
    end
    return r;
  endfunction

endpackage

[src/gsts_ctrl.sv]
// control state machine: request intake, probe sequencing, result hand-off
module gsts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  gsts_pkg::status_t status,
  output gsts_pkg::cmd_t    cmd
);

  gsts_pkg::state_t state;
  gsts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      gsts_pkg::ST_IDLE: begin
        // no intake while reset is held
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          if (status.mode == gsts_pkg::MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.advance = 1'b1;
            if (status.pos_zero) begin
              cmd.set_label = 1'b1;
            end else if (!status.count_zero) begin
              cmd.start  = 1'b1;
              state_next = gsts_pkg::ST_PROBE;
            end
          end
        end
      end
      gsts_pkg::ST_PROBE: begin
        cmd.probe  = 1'b1;
        state_next = gsts_pkg::ST_COMPARE;
      end
      gsts_pkg::ST_COMPARE: begin
        if (status.key_eq) begin
          // hold the hit until the output register can take it
          if (status.out_free) begin
            cmd.emit   = 1'b1;
            state_next = gsts_pkg::ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
          if (status.range_done) begin
            state_next = gsts_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = gsts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/gsts_dp.sv]
// datapath: key table memory, search bounds, group tracking, output register
`include "grouped_sorted_table_binary_search_defines.svh"

module gsts_dp #(
  parameter int unsigned TABLE_DEPTH = gsts_pkg::TableDepthDefault,
  parameter int unsigned KEY_BYTES   = gsts_pkg::KeyBytesDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [gsts_pkg::TEXT_W-1:0]     s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [2*gsts_pkg::TEXT_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [gsts_pkg::GS_W-1:0]       cfg_wdata,
  input  gsts_pkg::cmd_t                  cmd,
  output gsts_pkg::status_t               status
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [gsts_pkg::TEXT_W-1:0] mem [TABLE_DEPTH];
  logic [gsts_pkg::TEXT_W-1:0] rdata;

  logic [gsts_pkg::TEXT_W-1:0] norm;
  logic [gsts_pkg::TEXT_W-1:0] search_key;
  logic [gsts_pkg::TEXT_W-1:0] label;
  logic [gsts_pkg::TEXT_W-1:0] out_label;
  logic [gsts_pkg::TEXT_W-1:0] out_key;
  logic                        out_valid;

  logic [CW-1:0]               count;
  logic [CW-1:0]               lo;
  logic [CW-1:0]               hi;
  logic [CW-1:0]               lo_next;
  logic [CW-1:0]               hi_next;
  logic [CW:0]                 sum_cur;
  logic [CW:0]                 sum_next;
  logic [AW-1:0]               mid;
  logic [AW-1:0]               mid_cur;
  logic [AW-1:0]               mid_next;
  logic [AW-1:0]               rd_addr;
  logic                        rd_en;
  logic                        full;
  logic                        key_lt;
  logic                        key_gt;

  logic [gsts_pkg::GS_W-1:0]   group_size;
  logic [gsts_pkg::GS_W-1:0]   gs_eff;
  logic [gsts_pkg::POS_W-1:0]  line_pos;
  logic [gsts_pkg::GS_W-1:0]   pos_inc;

  assign norm = gsts_pkg::normalize(s_tdata, int'(KEY_BYTES));
  assign full = (count == CW'(TABLE_DEPTH));

  // search bounds are [lo, hi): mid is the floor midpoint of the inclusive range
  assign sum_cur  = {1'b0, lo} + {1'b0, hi} - (CW+1)'(1);
  assign mid_cur  = AW'(sum_cur >> 1);
  assign key_lt   = (search_key < rdata);
  assign key_gt   = (search_key > rdata);
  assign lo_next  = key_gt ? (CW'(mid) + CW'(1)) : lo;
  assign hi_next  = key_lt ? CW'(mid) : hi;
  assign sum_next = {1'b0, lo_next} + {1'b0, hi_next} - (CW+1)'(1);
  assign mid_next = AW'(sum_next >> 1);

  assign rd_en   = cmd.probe || (cmd.step && (lo_next < hi_next));
  assign rd_addr = cmd.step ? mid_next : mid_cur;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= norm;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (rd_en) begin
      mid <= rd_addr;
    end
    if (cmd.start) begin
      search_key <= norm;
    end
    if (cmd.emit) begin
      out_label <= label;
      out_key   <= search_key;
    end
  end

  // effective group size is clamped to 1..16
  always_comb begin
    priority if (group_size == '0) begin
      gs_eff = gsts_pkg::GS_MIN;
    end else if (group_size > gsts_pkg::GS_MAX) begin
      gs_eff = gsts_pkg::GS_MAX;
    end else begin
      gs_eff = group_size;
    end
  end

  assign pos_inc = {1'b0, line_pos} + gsts_pkg::GS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      line_pos   <= '0;
      label      <= '0;
      group_size <= gsts_pkg::GS_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        group_size <= cfg_wdata;
      end
      if (cmd.load && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.set_label) begin
        label <= norm;
      end
      if (cmd.advance) begin
        line_pos <= (pos_inc >= gs_eff) ? '0 : pos_inc[gsts_pkg::POS_W-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_key, out_label};

  assign status.mode       = s_tuser;
  assign status.pos_zero   = (line_pos == '0);
  assign status.count_zero = (count == '0);
  assign status.key_eq     = (search_key == rdata);
  assign status.range_done = !(lo_next < hi_next);
  assign status.out_free   = !out_valid || m_tready;

  `GSTS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "entry count beyond table depth")
  `GSTS_ASSERT_NOW(a_probe_range, cmd.probe || cmd.step, lo < hi, "probe with an empty search range")
  `GSTS_ASSERT_NOW(a_hi_bound, cmd.probe || cmd.step, hi <= count, "search bound above loaded entries")
  `GSTS_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid || m_tready, "result overwrites a pending one")

endmodule

[src/grouped_sorted_table_binary_search.sv]
// top level: grouped key lookup by binary search in a loaded sorted table
//
//   channel   dir  handshake          contents
//   s_*       in   s_tvalid/s_tready  tdata = text, tuser = mode (0 load key, 1 search line)
//   m_*       out  m_tvalid/m_tready  tdata = section_label, matched_key
//   cfg_*     in   cfg_we             cfg_wdata = group_size
//
// a load request or a group label request is handled in the idle state
// a search request passes the probe state, then one compare step per probe, at most
//   clog2(entries)+1 probes, set by the single read port of the key memory feeding
//   the compare loop
// a hit waits in the compare state while an earlier result is still pending
// rst is synchronous and clears the entry count, group position, label and
//   group size (back to 4); table contents are not cleared
// one request is worked on at a time; s_tready is high only between searches
module grouped_sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = gsts_pkg::TableDepthDefault,
  parameter int unsigned KEY_BYTES   = gsts_pkg::KeyBytesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // input requests
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gsts_pkg::TEXT_W-1:0]   s_tdata,   // [63:0] text
  input  logic                          s_tuser,   // [0] mode
  // results, one per table hit
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [2*gsts_pkg::TEXT_W-1:0] m_tdata,   // [63:0] section_label, [127:64] matched_key
  // group size register
  input  logic                          cfg_we,
  input  logic [gsts_pkg::GS_W-1:0]     cfg_wdata
);

  // command and status between the state machine and the datapath
  gsts_pkg::cmd_t    cmd;
  gsts_pkg::status_t status;

  // sequencing: intake, first probe, compare loop, result hand-off
  gsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // key memory, bounds, group position and output register
  gsts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
